// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked, reset-qualified concurrent assertions of the
// RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tqm_pkg.sv -----
// ----------------------------------------------------------------------------
// tqm_pkg
// Widths and constants shared by the triangle quality pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tqm_pkg;

  localparam int COORD_FRAC_BITS = 16;

  localparam int COORD_W   = 24;
  localparam int NUM_COORD = 9;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int E2_W      = PROD_W;
  localparam int EDGE_W    = E2_W / 2;
  localparam int CRM_W     = PROD_W;
  localparam int CRH_W     = CRM_W / 2;
  localparam int K2_W      = 2 * CRM_W;
  localparam int K_W       = K2_W / 2;
  localparam int PER_W     = EDGE_W + 2;
  localparam int BC_W      = 2 * EDGE_W;
  localparam int BCH_W     = BC_W / 2;
  localparam int PA_W      = PER_W + EDGE_W;
  localparam int PAH_W     = PA_W / 2;
  localparam int RP_W      = PAH_W + BCH_W;
  localparam int SQ3_W     = 31;
  localparam int L2H_W     = E2_W / 2;
  localparam int ALTP_W    = SQ3_W + L2H_W;
  localparam int DENR_W    = PA_W + BC_W;
  localparam int DENA_W    = SQ3_W + E2_W;
  localparam int NUMR_SH   = 18;
  localparam int NUMA_SH   = 47;
  localparam int NUMR_W    = K2_W + NUMR_SH;
  localparam int NUMA_W    = K_W + NUMA_SH;
  localparam int Q_W       = 17;
  localparam int AREA_W    = 32;
  localparam int LEDGE_W   = 24;

  localparam int IN_TDATA_W  = NUM_COORD * COORD_W;
  localparam int OUT_TDATA_W = 80;

  // sqrt(3) in Q1.30
  localparam logic [SQ3_W-1:0] SQRT3_Q30 = 31'd1859775393;
  localparam logic [Q_W-1:0]   ONE_Q16   = 17'd65536;

endpackage

`default_nettype wire

// ----- src/tqm_isqrt.sv -----
// ----------------------------------------------------------------------------
// tqm_isqrt
// Pipelined integer square root, one root bit per stage, with a side word
// that travels alongside the radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_isqrt
  import tqm_pkg::*;
#(
  parameter int RAD_W  = E2_W,
  parameter int SIDE_W = E2_W
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic      [RAD_W/2-1:0]   root_o,
  output logic      [SIDE_W-1:0]    side_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int TW     = RAD_W + 1;

  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  generate
    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int B = ROOT_W - 1 - i;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [SIDE_W-1:0] side_in;
      logic [TW-1:0]     trial;
      logic              fits;

      if (i == 0) begin : g_first
        assign rem_in  = rad_i;
        assign root_in = '0;
        assign side_in = side_i;
      end else begin : g_next
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
        assign side_in = side_r[i-1];
      end

      // rem holds n - r*r; setting bit B adds r*2^(B+1) + 2^(2B) to the square.
      assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
      assign fits  = {1'b0, rem_in} >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= fits ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
          root_r[i] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
          side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

`default_nettype wire

// ----- src/triangle_quality_measure.sv -----
// ----------------------------------------------------------------------------
// triangle_quality_measure
// Radius-ratio and altitude-ratio quality of a 3D triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one triangle per word: nine signed Q8.16
//   coordinates A, B, C (x, y, z each). The output stream carries one word per
//   triangle: quality (Q1.16, 65536 for an equilateral triangle), area,
//   longest edge and, in tuser, the degenerate flag.
//   A new triangle is taken in every cycle while in_tready is high; results
//   leave in input order.
//   The depth is set by the square root of the doubled area (50 stages, one
//   root bit each), six stages of products and sums ahead of it, and a
//   set-up stage and a 17-stage divider, one quotient bit per stage, after it.
//   When the receiver stalls, the finished word waits in the output register
//   and one more word goes into a skid register. Once the skid register is
//   full, in_tready drops and the whole pipeline holds until the receiver
//   takes the waiting word.
//   Reset clears all valid bits; words in flight are dropped and the block is
//   ready again in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module triangle_quality_measure
  import tqm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (24 bits each)
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // quality [16:0], tri_area [48:17], longest_edge [72:49], zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // degenerate
  output logic                        out_tuser
);

  localparam int DEN_DLY = K_W - EDGE_W - 4;
  localparam int DEPTH   = 6 + K_W + 1 + Q_W;

  typedef struct packed {
    logic [DENR_W-1:0] denr;
    logic [DENA_W-1:0] dena;
    logic [EDGE_W-1:0] lmax;
  } den_pkt_t;

  typedef struct packed {
    logic               ovf_r;
    logic               ovf_a;
    logic [AREA_W-1:0]  area;
    logic [LEDGE_W-1:0] ledge;
    logic               degen;
  } div_side_t;

  typedef struct packed {
    logic [Q_W-1:0]     qual;
    logic [AREA_W-1:0]  area;
    logic [LEDGE_W-1:0] ledge;
    logic               degen;
  } res_t;

  logic             en;
  logic [DEPTH-1:0] vld_r;

  // ---------------------------------------------------------------- stage 1
  logic signed [DIFF_W-1:0] ext [NUM_COORD];
  logic signed [DIFF_W-1:0] diff_r [3][3];
  logic signed [DIFF_W-1:0] ac_r [3];

  generate
    for (genvar g = 0; g < NUM_COORD; g++) begin : g_ext
      assign ext[g] = {in_tdata[g*COORD_W + COORD_W - 1], in_tdata[g*COORD_W +: COORD_W]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          diff_r[e][k] <= ext[((e + 1) % 3) * 3 + k] - ext[e * 3 + k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        ac_r[k] <= ext[6 + k] - ext[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [PROD_W-1:0] sq_r [3][3];
  logic signed [PROD_W-1:0] cp_r [3][2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          sq_r[e][k] <= diff_r[e][k] * diff_r[e][k];
        end
      end
      // Cross product of AB and AC, one term pair per component.
      for (int c = 0; c < 3; c++) begin
        cp_r[c][0] <= diff_r[0][(c + 1) % 3] * ac_r[(c + 2) % 3];
        cp_r[c][1] <= diff_r[0][(c + 2) % 3] * ac_r[(c + 1) % 3];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [PROD_W:0]  cd  [3];
  logic [PROD_W:0]  cda [3];
  logic [E2_W-1:0]  e2_s3_r [3];
  logic [CRM_W-1:0] crm_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cd[c]  = {cp_r[c][0][PROD_W-1], cp_r[c][0]} - {cp_r[c][1][PROD_W-1], cp_r[c][1]};
      cda[c] = cd[c][PROD_W] ? ((PROD_W+1)'(0) - cd[c]) : cd[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        e2_s3_r[e] <= E2_W'($unsigned(sq_r[e][0])) + E2_W'($unsigned(sq_r[e][1]))
                    + E2_W'($unsigned(sq_r[e][2]));
        crm_r[e]   <= cda[e][CRM_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------- stages 4 to 6
  logic [2*CRH_W-1:0] hh_r [3];
  logic [2*CRH_W-1:0] hl_r [3];
  logic [2*CRH_W-1:0] ll_r [3];
  logic [K2_W-1:0]    csq_r [3];
  logic [K2_W-1:0]    k2_r;
  logic [E2_W-1:0]    e2_s4_r [3];
  logic [E2_W-1:0]    e2_s5_r [3];
  logic [E2_W-1:0]    e2_s6_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        hh_r[c]    <= crm_r[c][CRM_W-1:CRH_W] * crm_r[c][CRM_W-1:CRH_W];
        hl_r[c]    <= crm_r[c][CRM_W-1:CRH_W] * crm_r[c][CRH_W-1:0];
        ll_r[c]    <= crm_r[c][CRH_W-1:0] * crm_r[c][CRH_W-1:0];
        csq_r[c]   <= (K2_W'(hh_r[c]) << (2 * CRH_W)) + (K2_W'(hl_r[c]) << (CRH_W + 1))
                    + K2_W'(ll_r[c]);
        e2_s4_r[c] <= e2_s3_r[c];
        e2_s5_r[c] <= e2_s4_r[c];
        e2_s6_r[c] <= e2_s5_r[c];
      end
      k2_r <= csq_r[0] + csq_r[1] + csq_r[2];
    end
  end

  // ----------------------------------------------------------- square roots
  logic [K_W-1:0]    k_root;
  logic [K2_W-1:0]   k2_late;
  logic [EDGE_W-1:0] len [3];
  logic [E2_W-1:0]   e2_late [3];

  tqm_isqrt #(
    .RAD_W  (K2_W),
    .SIDE_W (K2_W)
  ) u_k_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (k2_r),
    .side_i (k2_r),
    .root_o (k_root),
    .side_o (k2_late)
  );

  generate
    for (genvar g = 0; g < 3; g++) begin : g_edge
      tqm_isqrt #(
        .RAD_W  (E2_W),
        .SIDE_W (E2_W)
      ) u_edge_sqrt (
        .clk    (clk),
        .en     (en),
        .rad_i  (e2_s6_r[g]),
        .side_i (e2_s6_r[g]),
        .root_o (len[g]),
        .side_o (e2_late[g])
      );
    end
  endgenerate

  // ---------------------------------------------- denominators, 4 stages
  logic [E2_W-1:0]   l2_max;
  logic [EDGE_W-1:0] len_max;
  logic [PER_W-1:0]  per_r;
  logic [BC_W-1:0]   bcp_r;
  logic [BC_W-1:0]   bcp_s33_r;
  logic [EDGE_W-1:0] a_r;
  logic [E2_W-1:0]   l2_r;
  logic [EDGE_W-1:0] lmax_s32_r;
  logic [EDGE_W-1:0] lmax_s33_r;
  logic [EDGE_W-1:0] lmax_s34_r;
  logic [PA_W-1:0]   pa_r;
  logic [ALTP_W-1:0] ah_r;
  logic [ALTP_W-1:0] al_r;
  logic [RP_W-1:0]   rp_r [4];
  logic [DENA_W-1:0] dena_s34_r;
  den_pkt_t          den_s35_r;
  den_pkt_t          dly_r [DEN_DLY];

  always_comb begin
    l2_max  = e2_late[0];
    len_max = len[0];
    for (int e = 1; e < 3; e++) begin
      if (e2_late[e] > l2_max) begin
        l2_max = e2_late[e];
      end
      if (len[e] > len_max) begin
        len_max = len[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      per_r      <= PER_W'(len[0]) + PER_W'(len[1]) + PER_W'(len[2]);
      bcp_r      <= len[1] * len[2];
      a_r        <= len[0];
      l2_r       <= l2_max;
      lmax_s32_r <= len_max;

      pa_r       <= per_r * a_r;
      bcp_s33_r  <= bcp_r;
      ah_r       <= SQRT3_Q30 * l2_r[E2_W-1:L2H_W];
      al_r       <= SQRT3_Q30 * l2_r[L2H_W-1:0];
      lmax_s33_r <= lmax_s32_r;

      rp_r[0]    <= pa_r[PA_W-1:PAH_W] * bcp_s33_r[BC_W-1:BCH_W];
      rp_r[1]    <= pa_r[PA_W-1:PAH_W] * bcp_s33_r[BCH_W-1:0];
      rp_r[2]    <= pa_r[PAH_W-1:0] * bcp_s33_r[BC_W-1:BCH_W];
      rp_r[3]    <= pa_r[PAH_W-1:0] * bcp_s33_r[BCH_W-1:0];
      dena_s34_r <= (DENA_W'(ah_r) << L2H_W) + DENA_W'(al_r);
      lmax_s34_r <= lmax_s33_r;

      den_s35_r.denr <= (DENR_W'(rp_r[0]) << (PAH_W + BCH_W)) + (DENR_W'(rp_r[1]) << PAH_W)
                      + (DENR_W'(rp_r[2]) << BCH_W) + DENR_W'(rp_r[3]);
      den_s35_r.dena <= dena_s34_r;
      den_s35_r.lmax <= lmax_s34_r;

      // Hold the denominators until the area root catches up.
      dly_r[0] <= den_s35_r;
      for (int d = 1; d < DEN_DLY; d++) begin
        dly_r[d] <= dly_r[d-1];
      end
    end
  end

  // ------------------------------------------------------- divider set-up
  den_pkt_t          den_al;
  logic [NUMR_W-1:0] numr;
  logic [NUMA_W-1:0] numa;
  logic [K_W-1:0]    area_full;
  div_side_t         su_side;
  logic [NUMR_W-1:0] su_numr_r;
  logic [NUMA_W-1:0] su_numa_r;
  logic [DENR_W-1:0] su_denr_r;
  logic [DENA_W-1:0] su_dena_r;
  div_side_t         su_side_r;

  always_comb begin
    den_al          = dly_r[DEN_DLY-1];
    numr            = NUMR_W'(k2_late) << NUMR_SH;
    numa            = NUMA_W'(k_root) << NUMA_SH;
    area_full       = k_root >> (COORD_FRAC_BITS + 1);
    su_side.ovf_r   = {1'b0, numr} >= ((NUMR_W+1)'(den_al.denr) << Q_W);
    su_side.ovf_a   = {1'b0, numa} >= ((NUMA_W+1)'(den_al.dena) << Q_W);
    su_side.area    = (|area_full[K_W-1:AREA_W]) ? '1 : area_full[AREA_W-1:0];
    su_side.ledge   = den_al.lmax[EDGE_W-1] ? '1 : den_al.lmax[LEDGE_W-1:0];
    su_side.degen   = (k2_late == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_numr_r <= numr;
      su_numa_r <= numa;
      su_denr_r <= den_al.denr;
      su_dena_r <= den_al.dena;
      su_side_r <= su_side;
    end
  end

  // -------------------------------------------- restoring divider stages
  logic [NUMR_W-1:0] dr_rem_r [Q_W];
  logic [NUMA_W-1:0] da_rem_r [Q_W];
  logic [Q_W-1:0]    dr_q_r   [Q_W];
  logic [Q_W-1:0]    da_q_r   [Q_W];
  logic [DENR_W-1:0] dr_den_r [Q_W];
  logic [DENA_W-1:0] da_den_r [Q_W];
  div_side_t         dv_side_r [Q_W];

  generate
    for (genvar i = 0; i < Q_W; i++) begin : g_div
      localparam int J = Q_W - 1 - i;
      logic [NUMR_W-1:0] r_rem_in;
      logic [NUMA_W-1:0] a_rem_in;
      logic [Q_W-1:0]    r_q_in;
      logic [Q_W-1:0]    a_q_in;
      logic [DENR_W-1:0] r_den_in;
      logic [DENA_W-1:0] a_den_in;
      div_side_t         side_in;
      logic [NUMR_W-1:0] r_sub;
      logic [NUMA_W-1:0] a_sub;

      if (i == 0) begin : g_first
        assign r_rem_in = su_numr_r;
        assign a_rem_in = su_numa_r;
        assign r_q_in   = '0;
        assign a_q_in   = '0;
        assign r_den_in = su_denr_r;
        assign a_den_in = su_dena_r;
        assign side_in  = su_side_r;
      end else begin : g_next
        assign r_rem_in = dr_rem_r[i-1];
        assign a_rem_in = da_rem_r[i-1];
        assign r_q_in   = dr_q_r[i-1];
        assign a_q_in   = da_q_r[i-1];
        assign r_den_in = dr_den_r[i-1];
        assign a_den_in = da_den_r[i-1];
        assign side_in  = dv_side_r[i-1];
      end

      assign r_sub = NUMR_W'(r_den_in) << J;
      assign a_sub = NUMA_W'(a_den_in) << J;

      always_ff @(posedge clk) begin
        if (en) begin
          if (r_rem_in >= r_sub) begin
            dr_rem_r[i] <= r_rem_in - r_sub;
            dr_q_r[i]   <= r_q_in | (Q_W'(1) << J);
          end else begin
            dr_rem_r[i] <= r_rem_in;
            dr_q_r[i]   <= r_q_in;
          end
          if (a_rem_in >= a_sub) begin
            da_rem_r[i] <= a_rem_in - a_sub;
            da_q_r[i]   <= a_q_in | (Q_W'(1) << J);
          end else begin
            da_rem_r[i] <= a_rem_in;
            da_q_r[i]   <= a_q_in;
          end
          dr_den_r[i]  <= r_den_in;
          da_den_r[i]  <= a_den_in;
          dv_side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  // ------------------------------------------------- terms and quality
  div_side_t    fin_side;
  logic [Q_W-1:0] term_r;
  logic [Q_W-1:0] term_a;
  logic [Q_W:0]   term_sum;
  res_t           fin;

  always_comb begin
    fin_side   = dv_side_r[Q_W-1];
    term_r     = (fin_side.ovf_r || (dr_q_r[Q_W-1] > ONE_Q16)) ? ONE_Q16 : dr_q_r[Q_W-1];
    term_a     = (fin_side.ovf_a || (da_q_r[Q_W-1] > ONE_Q16)) ? ONE_Q16 : da_q_r[Q_W-1];
    term_sum   = {1'b0, term_r} + {1'b0, term_a};
    fin.qual   = fin_side.degen ? '0 : term_sum[Q_W:1];
    fin.area   = fin_side.area;
    fin.ledge  = fin_side.ledge;
    fin.degen  = fin_side.degen;
  end

  // ------------------------------------------- output register and skid
  logic out_vld_r;
  logic skid_vld_r;
  logic out_free;
  logic last_vld;
  res_t out_pl_r;
  res_t skid_pl_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign out_free  = !out_vld_r || out_tready;
  assign last_vld  = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || last_vld;
      skid_vld_r <= 1'b0;
    end else if (last_vld && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pl_r <= skid_vld_r ? skid_pl_r : fin;
    end
    if (!out_free && en) begin
      skid_pl_r <= fin;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - Q_W - AREA_W - LEDGE_W)'(0),
                       out_pl_r.ledge, out_pl_r.area, out_pl_r.qual};
  assign out_tuser  = out_pl_r.degen;

  // ------------------------------------------------------------ assertions
  `ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_vld_r, out_vld_r, "lone skid word")
  `ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_vld_r && out_tready, out_vld_r && !skid_vld_r, "skid stuck")
  `ASSERT_IMPL(a_degen_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata[48:0] == '0, "degen nonzero")
  `ASSERT_IMPL(a_quality_max, clk, rst_n, out_tvalid, out_tdata[Q_W-1:0] <= ONE_Q16, "quality above one")

endmodule

`default_nettype wire
